FILE: sv/rlg_pkg.sv
// Package: shared types, constants and helpers of the letterbox geometry unit.
`default_nettype none
package rlg_pkg;

  // Dimension limits and datapath widths
  localparam int unsigned MAX_DIM = 16384;
  localparam int unsigned DIM_W   = 15;
  localparam int unsigned PAD_W   = 14;
  localparam int unsigned ALN_W   = 9;
  localparam int unsigned NUM_W   = 30;            // dividend bits, one cell per bit
  localparam int unsigned DEN_W   = 16;            // divisor bits
  localparam int unsigned REM_W   = DEN_W + 1;
  localparam int unsigned N_LANES = 3;
  localparam int unsigned N_CELLS = NUM_W;

  // Divider lanes
  localparam int unsigned LANE_SCALE = 0;          // keep-ratio scaled side
  localparam int unsigned LANE_ALN_W = 1;          // width rounded up to multiple
  localparam int unsigned LANE_ALN_H = 2;          // height rounded up to multiple

  // Resize modes
  localparam logic [2:0] MODE_LETTERBOX  = 3'd0;
  localparam logic [2:0] MODE_PAD_CENTER = 3'd1;
  localparam logic [2:0] MODE_PAD_ZERO   = 3'd2;
  localparam logic [2:0] MODE_CROP       = 3'd3;
  localparam logic [2:0] MODE_DIRECT     = 3'd4;
  localparam logic [2:0] MODE_ALIGN      = 3'd5;
  localparam logic [2:0] MODE_NONE       = 3'd6;
  localparam logic [2:0] MODE_PAD_MULT   = 3'd7;

  // Register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_NET_W    = 3'd1;
  localparam logic [2:0] REG_NET_H    = 3'd2;
  localparam logic [2:0] REG_ALIGN    = 3'd3;
  localparam logic [2:0] REG_PRE_W    = 3'd4;
  localparam logic [2:0] REG_PRE_H    = 3'd5;

  typedef struct packed {
    logic [NUM_W-1:0] num;   // dividend bits shift out, quotient bits shift in
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] rem;
  } lane_t;

  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic             hsel;  // height ratio is the smaller one or ties
    lane_t [N_LANES-1:0] lane;
  } stage_t;

  // Clamp a size to [1, MAX_DIM]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  // Clamp an optional size to at most MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_opt(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rlg_cell.sv
// Cell: one restoring-division step on every lane, with its own valid and handshake.
`default_nettype none
module rlg_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire rlg_pkg::stage_t stage_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output rlg_pkg::stage_t      stage_o
);

  logic            valid_q;
  rlg_pkg::stage_t stage_q, stage_d;

  // Take a word when empty or when the neighbor takes ours
  assign ready_o = !valid_q || ready_i;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    logic [rlg_pkg::REM_W-1:0] rem_sh;
    logic                      fits;
    stage_d = stage_i;
    for (int l = 0; l < rlg_pkg::N_LANES; l++) begin
      rem_sh = {stage_i.lane[l].rem[rlg_pkg::DEN_W-1:0],
                stage_i.lane[l].num[rlg_pkg::NUM_W-1]};
      fits   = rem_sh >= {1'b0, stage_i.lane[l].den};
      stage_d.lane[l].rem = fits ? rem_sh - {1'b0, stage_i.lane[l].den} : rem_sh;
      stage_d.lane[l].num = {stage_i.lane[l].num[rlg_pkg::NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

FILE: sv/resize_letterbox_geometry.sv
// Top level: letterbox / resize geometry unit built on a chain of divider cells.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  in       | in_valid_i / in_stall_o    | source_width_i, source_height_i
//  out      | out_valid_o / out_stall_i  | out/content size, pad and crop offsets
//
// The path is 30 division cells (one quotient bit each) and then the output register.
// A word enters every cycle unless stalled; each cell hands words on, so bubbles close.
// Reset clears all valid bits and loads the register defaults; cfg is always ready.
// While out_stall_i holds, the chain fills and then stalls the input.
`default_nettype none
module resize_letterbox_geometry (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [2:0]                  cfg_index_i,
  input  wire logic [rlg_pkg::DIM_W-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rlg_pkg::DIM_W-1:0]   source_width_i,
  input  wire logic [rlg_pkg::DIM_W-1:0]   source_height_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [rlg_pkg::DIM_W-1:0]        out_width_o,
  output logic [rlg_pkg::DIM_W-1:0]        out_height_o,
  output logic [rlg_pkg::DIM_W-1:0]        content_width_o,
  output logic [rlg_pkg::DIM_W-1:0]        content_height_o,
  output logic [rlg_pkg::PAD_W-1:0]        pad_left_o,
  output logic [rlg_pkg::PAD_W-1:0]        pad_top_o,
  output logic [rlg_pkg::PAD_W-1:0]        crop_left_o,
  output logic [rlg_pkg::PAD_W-1:0]        crop_top_o
);

  localparam int unsigned DW = rlg_pkg::DIM_W;
  localparam int unsigned PW = rlg_pkg::PAD_W;
  localparam int unsigned NW = rlg_pkg::NUM_W;
  localparam int unsigned NC = rlg_pkg::N_CELLS;

  // Configuration registers
  logic [2:0]                   mode_q;
  logic [DW-1:0]                net_w_q, net_h_q, pre_w_q, pre_h_q;
  logic [rlg_pkg::ALN_W-1:0]    align_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rlg_pkg::MODE_LETTERBOX;
      net_w_q <= DW'(640);
      net_h_q <= DW'(640);
      align_q <= rlg_pkg::ALN_W'(32);
      pre_w_q <= '0;
      pre_h_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rlg_pkg::REG_MODE:  mode_q  <= cfg_data_i[2:0];
        rlg_pkg::REG_NET_W: net_w_q <= cfg_data_i;
        rlg_pkg::REG_NET_H: net_h_q <= cfg_data_i;
        rlg_pkg::REG_ALIGN: align_q <= cfg_data_i[rlg_pkg::ALN_W-1:0];
        rlg_pkg::REG_PRE_W: pre_w_q <= cfg_data_i;
        rlg_pkg::REG_PRE_H: pre_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped register views
  logic [DW-1:0]             nw, nh, pw, ph;
  logic [rlg_pkg::ALN_W-1:0] m;
  assign nw = rlg_pkg::clamp_dim(net_w_q);
  assign nh = rlg_pkg::clamp_dim(net_h_q);
  assign pw = rlg_pkg::clamp_opt(pre_w_q);
  assign ph = rlg_pkg::clamp_opt(pre_h_q);
  assign m  = (align_q == '0) ? rlg_pkg::ALN_W'(1) : align_q;

  // Set up the three divisions for the incoming word
  logic [DW-1:0]   sw, sh, vw, vh;
  logic [NW-1:0]   p_h, p_w;
  rlg_pkg::stage_t setup;

  assign sw  = rlg_pkg::clamp_dim(source_width_i);
  assign sh  = rlg_pkg::clamp_dim(source_height_i);
  assign p_h = NW'(nh) * NW'(sw);
  assign p_w = NW'(nw) * NW'(sh);
  assign vw  = (mode_q == rlg_pkg::MODE_PAD_MULT && pw != '0) ? pw : sw;
  assign vh  = (mode_q == rlg_pkg::MODE_PAD_MULT && ph != '0) ? ph : sh;

  always_comb begin
    setup      = '0;
    setup.sw   = sw;
    setup.sh   = sh;
    setup.hsel = p_h <= p_w;
    if (setup.hsel) begin
      setup.lane[rlg_pkg::LANE_SCALE].num = {p_h[NW-2:0], 1'b0} + NW'(sh);
      setup.lane[rlg_pkg::LANE_SCALE].den = {sh, 1'b0};
    end else begin
      setup.lane[rlg_pkg::LANE_SCALE].num = {p_w[NW-2:0], 1'b0} + NW'(sw);
      setup.lane[rlg_pkg::LANE_SCALE].den = {sw, 1'b0};
    end
    setup.lane[rlg_pkg::LANE_ALN_W].num = NW'(vw) + NW'(m) - NW'(1);
    setup.lane[rlg_pkg::LANE_ALN_W].den = rlg_pkg::DEN_W'(m);
    setup.lane[rlg_pkg::LANE_ALN_H].num = NW'(vh) + NW'(m) - NW'(1);
    setup.lane[rlg_pkg::LANE_ALN_H].den = rlg_pkg::DEN_W'(m);
  end

  // Division chain
  logic            cv[0:NC];
  logic            cr[0:NC];
  rlg_pkg::stage_t cs[0:NC];

  assign cv[0]      = in_valid_i;
  assign cs[0]      = setup;
  assign in_stall_o = !cr[0];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    rlg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .stage_i (cs[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .stage_o (cs[g+1])
    );
  end

  // Finish: clamp scaled side, align products, offsets per mode
  logic                out_valid_q;
  logic [DW-1:0]       ow_d, oh_d, cw_d, ch_d, ow_q, oh_q, cw_q, ch_q;
  logic [PW-1:0]       px_d, py_d, cx_d, cy_d, px_q, py_q, cx_q, cy_q;
  logic [NW-1:0]       qa, qb, qc;
  logic [DW-1:0]       scw, sch, rw, rh, pre_w, pre_h, cwp, chp;
  logic [DW+rlg_pkg::ALN_W-1:0] rw_full, rh_full;

  assign cr[NC] = !out_valid_q || !out_stall_i;
  assign qa = cs[NC].lane[rlg_pkg::LANE_SCALE].num;
  assign qb = cs[NC].lane[rlg_pkg::LANE_ALN_W].num;
  assign qc = cs[NC].lane[rlg_pkg::LANE_ALN_H].num;
  assign rw_full = qb[DW-1:0] * m;
  assign rh_full = qc[DW-1:0] * m;
  assign rw = rw_full[DW-1:0];
  assign rh = rh_full[DW-1:0];
  assign pre_w = (pw != '0) ? pw : nw;
  assign pre_h = (ph != '0) ? ph : nh;

  always_comb begin
    scw = nw;
    sch = nh;
    if (cs[NC].hsel) begin
      scw = (qa > NW'(nw)) ? nw : qa[DW-1:0];
    end else begin
      sch = (qa > NW'(nh)) ? nh : qa[DW-1:0];
    end
    cwp = nw - scw;
    chp = nh - sch;
  end

  always_comb begin
    ow_d = nw;
    oh_d = nh;
    cw_d = nw;
    ch_d = nh;
    px_d = '0;
    py_d = '0;
    cx_d = '0;
    cy_d = '0;
    case (mode_q) inside
      rlg_pkg::MODE_LETTERBOX, rlg_pkg::MODE_PAD_CENTER: begin
        cw_d = scw;
        ch_d = sch;
        px_d = cwp[DW-1:1];
        py_d = chp[DW-1:1];
      end
      rlg_pkg::MODE_PAD_ZERO: begin
        cw_d = scw;
        ch_d = sch;
      end
      rlg_pkg::MODE_CROP: begin
        cw_d = pre_w;
        ch_d = pre_h;
        cx_d = (pre_w > nw) ? PW'((pre_w - nw) >> 1) : '0;
        cy_d = (pre_h > nh) ? PW'((pre_h - nh) >> 1) : '0;
      end
      rlg_pkg::MODE_DIRECT: ;
      rlg_pkg::MODE_ALIGN: begin
        ow_d = rw;
        oh_d = rh;
        cw_d = rw;
        ch_d = rh;
      end
      rlg_pkg::MODE_NONE: begin
        ow_d = cs[NC].sw;
        oh_d = cs[NC].sh;
        cw_d = cs[NC].sw;
        ch_d = cs[NC].sh;
      end
      default: begin
        cw_d = (pw != '0) ? pw : cs[NC].sw;
        ch_d = (ph != '0) ? ph : cs[NC].sh;
        ow_d = rw;
        oh_d = rh;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cr[NC]) begin
      out_valid_q <= cv[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr[NC] && cv[NC]) begin
      ow_q <= ow_d;
      oh_q <= oh_d;
      cw_q <= cw_d;
      ch_q <= ch_d;
      px_q <= px_d;
      py_q <= py_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_width_o      = ow_q;
  assign out_height_o     = oh_q;
  assign content_width_o  = cw_q;
  assign content_height_o = ch_q;
  assign pad_left_o       = px_q;
  assign pad_top_o        = py_q;
  assign crop_left_o      = cx_q;
  assign crop_top_o       = cy_q;

  // Checks
  a_pad_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == rlg_pkg::MODE_LETTERBOX || mode_q == rlg_pkg::MODE_PAD_CENTER)
    |-> ({1'b0, pad_left_o, 1'b0} + {1'b0, content_width_o}) <= {1'b0, out_width_o})
    else $error("letterbox padding exceeds output width");

  a_same_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_q == rlg_pkg::MODE_DIRECT || mode_q == rlg_pkg::MODE_ALIGN ||
                    mode_q == rlg_pkg::MODE_NONE)
    |-> content_width_o == out_width_o && content_height_o == out_height_o)
    else $error("content and output size differ in a plain resize mode");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> cv[1])
    else $error("input stalled while first cell is empty");

endmodule
`default_nettype wire

FILE: dv/tb_resize_letterbox_geometry.sv
// Testbench: letterbox / resize geometry unit checked against an in-bench geometry predictor.
`default_nettype none
module tb_resize_letterbox_geometry;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LATENCY     = 31;
  localparam int unsigned DIM_W       = rlg_pkg::DIM_W;
  localparam int unsigned PAD_W       = rlg_pkg::PAD_W;
  localparam int unsigned ALN_W       = rlg_pkg::ALN_W;
  localparam int unsigned MAX_DIM     = rlg_pkg::MAX_DIM;

  typedef struct packed {
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] ch;
    logic [PAD_W-1:0] px;
    logic [PAD_W-1:0] py;
    logic [PAD_W-1:0] cx;
    logic [PAD_W-1:0] cy;
  } geom_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [DIM_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [DIM_W-1:0] source_width_i = '0;
  logic [DIM_W-1:0] source_height_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  geom_t got;

  resize_letterbox_geometry i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .source_width_i, .source_height_i,
    .out_valid_o, .out_stall_i,
    .out_width_o(got.ow), .out_height_o(got.oh),
    .content_width_o(got.cw), .content_height_o(got.ch),
    .pad_left_o(got.px), .pad_top_o(got.py),
    .crop_left_o(got.cx), .crop_top_o(got.cy)
  );

  // Shadow copy of the registers
  logic [2:0]       mode_q;
  logic [DIM_W-1:0] net_w_q, net_h_q, pre_w_q, pre_h_q;
  logic [ALN_W-1:0] align_q;

  geom_t expected_geoms[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0, words_checked = 0;
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned dim_clamp(longint unsigned v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic longint unsigned round_up(longint unsigned v, longint unsigned m);
    return ((v + m - 1) / m) * m;
  endfunction

  function automatic longint unsigned sat_to(longint unsigned v, int unsigned bits);
    longint unsigned lim;
    lim = (64'd1 << bits) - 1;
    return (v > lim) ? lim : v;
  endfunction

  // Compute the geometry of one source size under the shadow registers
  function automatic geom_t predict_geometry(logic [DIM_W-1:0] src_w, logic [DIM_W-1:0] src_h);
    longint unsigned sw, sh, nw, nh, pw, ph, m, ow, oh, cw, ch, px, py, cx, cy;
    geom_t g;
    sw = dim_clamp(src_w);
    sh = dim_clamp(src_h);
    nw = dim_clamp(net_w_q);
    nh = dim_clamp(net_h_q);
    pw = (pre_w_q > MAX_DIM) ? MAX_DIM : pre_w_q;
    ph = (pre_h_q > MAX_DIM) ? MAX_DIM : pre_h_q;
    m = (align_q == 0) ? 1 : align_q;
    ow = nw; oh = nh; cw = 0; ch = 0; px = 0; py = 0; cx = 0; cy = 0;
    case (mode_q) inside
      rlg_pkg::MODE_LETTERBOX, rlg_pkg::MODE_PAD_CENTER, rlg_pkg::MODE_PAD_ZERO: begin
        if (nh * sw <= nw * sh) begin
          cw = (2 * sw * nh + sh) / (2 * sh);
          ch = (2 * sh * nh + sh) / (2 * sh);
        end else begin
          cw = (2 * sw * nw + sw) / (2 * sw);
          ch = (2 * sh * nw + sw) / (2 * sw);
        end
        if (cw > nw) cw = nw;
        if (ch > nh) ch = nh;
        if (mode_q != rlg_pkg::MODE_PAD_ZERO) begin
          px = (nw - cw) / 2;
          py = (nh - ch) / 2;
        end
      end
      rlg_pkg::MODE_CROP: begin
        cw = (pw > 0) ? pw : nw;
        ch = (ph > 0) ? ph : nh;
        cx = (cw > nw) ? (cw - nw) / 2 : 0;
        cy = (ch > nh) ? (ch - nh) / 2 : 0;
      end
      rlg_pkg::MODE_DIRECT: begin
        cw = nw;
        ch = nh;
      end
      rlg_pkg::MODE_ALIGN: begin
        ow = round_up(sw, m);
        oh = round_up(sh, m);
        cw = ow;
        ch = oh;
      end
      rlg_pkg::MODE_NONE: begin
        ow = sw; oh = sh; cw = sw; ch = sh;
      end
      default: begin
        cw = (pw > 0) ? pw : sw;
        ch = (ph > 0) ? ph : sh;
        ow = round_up(cw, m);
        oh = round_up(ch, m);
      end
    endcase
    g.ow = DIM_W'(sat_to(ow, DIM_W));
    g.oh = DIM_W'(sat_to(oh, DIM_W));
    g.cw = DIM_W'(sat_to(cw, DIM_W));
    g.ch = DIM_W'(sat_to(ch, DIM_W));
    g.px = PAD_W'(sat_to(px, PAD_W));
    g.py = PAD_W'(sat_to(py, PAD_W));
    g.cx = PAD_W'(sat_to(cx, PAD_W));
    g.cy = PAD_W'(sat_to(cy, PAD_W));
    return g;
  endfunction

  // Run-length watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive receiver stall: long hold-off first, then random idling
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    geom_t exp_g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_geoms.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        exp_g = expected_geoms.pop_front();
        words_checked++;
        if (got.ow !== exp_g.ow) begin
          $error("out_width exp %0d got %0d", exp_g.ow, got.ow); errors++;
        end
        if (got.oh !== exp_g.oh) begin
          $error("out_height exp %0d got %0d", exp_g.oh, got.oh); errors++;
        end
        if (got.cw !== exp_g.cw) begin
          $error("content_width exp %0d got %0d", exp_g.cw, got.cw); errors++;
        end
        if (got.ch !== exp_g.ch) begin
          $error("content_height exp %0d got %0d", exp_g.ch, got.ch); errors++;
        end
        if (got.px !== exp_g.px) begin
          $error("pad_left exp %0d got %0d", exp_g.px, got.px); errors++;
        end
        if (got.py !== exp_g.py) begin
          $error("pad_top exp %0d got %0d", exp_g.py, got.py); errors++;
        end
        if (got.cx !== exp_g.cx) begin
          $error("crop_left exp %0d got %0d", exp_g.cx, got.cx); errors++;
        end
        if (got.cy !== exp_g.cy) begin
          $error("crop_top exp %0d got %0d", exp_g.cy, got.cy); errors++;
        end
      end
    end
  end

  // Offer one source size, with a random gap first, and hold until accepted;
  // valid stays high afterwards so the next word can follow directly
  task automatic send_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    source_width_i  <= w;
    source_height_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_geoms.push_back(predict_geometry(w, h));
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for all predictions to drain, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_geoms.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Write one register while the block is idle and update the shadow copy
  task automatic write_reg(logic [2:0] idx, logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      rlg_pkg::REG_MODE:  mode_q  = val[2:0];
      rlg_pkg::REG_NET_W: net_w_q = val;
      rlg_pkg::REG_NET_H: net_h_q = val;
      rlg_pkg::REG_ALIGN: align_q = val[ALN_W-1:0];
      rlg_pkg::REG_PRE_W: pre_w_q = val;
      rlg_pkg::REG_PRE_H: pre_h_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode_regs(logic [2:0] mode, logic [DIM_W-1:0] nw, logic [DIM_W-1:0] nh,
                               logic [DIM_W-1:0] al, logic [DIM_W-1:0] pw,
                               logic [DIM_W-1:0] ph);
    write_reg(rlg_pkg::REG_MODE, DIM_W'(mode));
    write_reg(rlg_pkg::REG_NET_W, nw);
    write_reg(rlg_pkg::REG_NET_H, nh);
    write_reg(rlg_pkg::REG_ALIGN, al);
    write_reg(rlg_pkg::REG_PRE_W, pw);
    write_reg(rlg_pkg::REG_PRE_H, ph);
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(9))
      0: return DIM_W'($urandom_range(32767));
      1: return DIM_W'($urandom_range(3));
      2: return DIM_W'($urandom_range(16390, 16380));
      3, 4: return DIM_W'($urandom_range(16384, 1));
      default: return DIM_W'($urandom_range(2000, 1));
    endcase
  endfunction

  // Directed: extremes of sizes in every mode, including the special cases
  task automatic test_directed();
    logic [DIM_W-1:0] edges[6];
    edges = '{15'd0, 15'd1, 15'd640, 15'd16384, 15'd16385, 15'h7FFF};
    for (int md = 0; md < 8; md++) begin
      set_mode_regs(md[2:0], (md[2:0] == rlg_pkg::MODE_CROP) ? 15'd100 : 15'd640, 15'd480,
                    15'd32, (md >= 3) ? 15'h7FFF : 15'd0, 15'd0);
      send_size(edges[md % 6], edges[(md + 2) % 6]);
      send_size(15'd1920, 15'd1080);
      send_size(15'd5, 15'h7FFF);
      drain();
    end
    // zero align multiple, zero network size, maximum multiple
    set_mode_regs(rlg_pkg::MODE_PAD_MULT, 15'd0, 15'h7FFF, 15'd0, 15'd0, 15'd16384);
    send_size(15'd333, 15'd16384);
    drain();
    write_reg(rlg_pkg::REG_ALIGN, 15'h1FF);
    send_size(15'd16384, 15'd1);
    drain();
    write_reg(rlg_pkg::REG_ALIGN, 15'd256);
    send_size(15'd16383, 15'd16384);
    drain();
    // indexes past the last register: ignored
    write_reg(3'd7, 15'h5A5A);
    write_reg(3'd6, 15'h2A5A);
    send_size(15'd16384, 15'd16384);
    drain();
  endtask

  // Random: many settings, random sizes, under the current idling split
  task automatic test_random(int unsigned n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        drain();
        set_mode_regs(3'($urandom_range(7)),
                      ($urandom_range(3) == 0) ? rand_dim() : 15'($urandom_range(1024, 16)),
                      ($urandom_range(3) == 0) ? rand_dim() : 15'($urandom_range(1024, 16)),
                      15'($urandom_range(511)),
                      ($urandom_range(1) == 0) ? 15'd0 : rand_dim(),
                      ($urandom_range(1) == 0) ? 15'd0 : rand_dim());
      end
      send_size(rand_dim(), rand_dim());
    end
    drain();
  endtask

  // Pressure: hold the receiver off long enough that the chain fills up
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_size(rand_dim(), rand_dim());
    drain();
  endtask

  initial begin
    mode_q = rlg_pkg::MODE_LETTERBOX; net_w_q = 15'd640; net_h_q = 15'd640;
    align_q = 9'd32; pre_w_q = '0; pre_h_q = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    send_idle_pct = 12; recv_idle_pct = 49;
    test_random(600);
    test_backpressure();
    send_idle_pct = 49; recv_idle_pct = 12;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(600);
    $display("Ran %0d source sizes over all eight resize modes and %0d results checked.",
             words_sent, words_checked);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
